### src/sqs_pkg.sv
package sqs_pkg;

  // Store geometry
  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 4;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [FILL_W-1:0]        fill_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic {
    MODE_STACK = 1'b0,
    MODE_QUEUE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_MATCH    = 3'd4,
    ST_LISTED   = 3'd5
  } status_t;

  // What every cell of the row does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,
    CELL_SHIFT_FWD,
    CELL_LOAD_AT,
    CELL_ROTATE,
    CELL_COMPARE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    value;
    fill_t    fill;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_LIST
  } fsm_t;

endpackage

### src/sqs_ifs.sv
interface sqs_in_if;
  logic             valid;
  logic             ready;
  sqs_pkg::action_t action;
  sqs_pkg::word_t   value;
  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sqs_out_if;
  logic             valid;
  logic             ready;
  sqs_pkg::status_t status;
  sqs_pkg::word_t   value_res;
  sqs_pkg::pos_t    position;
  logic             last;
  modport source (output valid, output status, output value_res, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input value_res, input position,
                  input last, output ready);
endinterface

interface sqs_cfg_if;
  logic           valid;
  logic           ready;
  sqs_pkg::mode_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/sqs_cell.sv
module sqs_cell (
  input  logic               clk,
  input  sqs_pkg::cell_ctl_t ctl,
  input  sqs_pkg::idx_t      idx,
  input  sqs_pkg::word_t     prev_word,
  input  sqs_pkg::word_t     next_word,
  input  sqs_pkg::word_t     head_word,
  output sqs_pkg::word_t     word,
  output logic               hit
);
  import sqs_pkg::*;

  word_t word_r, word_nxt;
  logic  hit_r, hit_nxt;
  fill_t my_pos;

  assign my_pos = FILL_W'(idx);

  // Cell update: shift, load, rotate or compare against the key
  always_comb begin
    word_nxt = word_r;
    hit_nxt  = hit_r;
    unique case (ctl.op)
      CELL_HOLD: ;
      CELL_SHIFT_BACK: begin
        word_nxt = (idx == '0) ? ctl.value : prev_word;
      end
      CELL_SHIFT_FWD: begin
        word_nxt = next_word;
      end
      CELL_LOAD_AT: begin
        if (my_pos == ctl.fill) word_nxt = ctl.value;
      end
      CELL_ROTATE: begin
        if (my_pos + FILL_W'(1) == ctl.fill) begin
          word_nxt = head_word;
        end else if (my_pos < ctl.fill) begin
          word_nxt = next_word;
        end
      end
      CELL_COMPARE: begin
        hit_nxt = (word_r == ctl.value) && (my_pos < ctl.fill);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    hit_r  <= hit_nxt;
  end

  assign word = word_r;
  assign hit  = hit_r;

endmodule

### src/stack_or_queue_with_search.sv
// Stack or queue of signed 32-bit words with search and list.
// Channels: in_ch carries requests (action, value), out_ch carries results
// (status, value_res, position, last), cfg_ch writes the mode bit (0 stack,
// 1 queue); cfg_ch is always ready and must be written only while the block
// idles, a rule on the user that the block does not enforce. Words sit in a
// row of DEPTH cells ordered from the front; stack pushes and all pops shift
// the row, queue pushes load the cell at the fill count, and list rotates it
// one cell per cycle past the front while out_ch takes results. Push and pop
// give one result in the cycle after the item is accepted, and a new item can
// be taken each cycle while out_ch drains. Search compares all cells in the
// accept cycle, then walks one position per cycle while out_ch is free, up to
// the last match. List gives one listed entry per cycle while out_ch is free.
// A new item is taken only after the previous one has issued all its results.
// Reset clears the state, mode, the fill count and the output valid bit;
// stored words are undefined until pushed. When out_ch stalls the walk holds
// in place and the pending result stays on out_ch.
module stack_or_queue_with_search (
  input logic       clk,
  input logic       rst_n,
  sqs_cfg_if.sink   cfg_ch,
  sqs_in_if.sink    in_ch,
  sqs_out_if.source out_ch
);
  import sqs_pkg::*;

  fsm_t      state_r, state_nxt;
  mode_t     mode_r;
  fill_t     fill_r, fill_nxt;
  idx_t      pos_r, pos_nxt;
  cnt_t      cnt_r, cnt_nxt;
  word_t     key_r, key_nxt;

  logic      out_valid_r, out_valid_nxt;
  status_t   out_status_r, out_status_nxt;
  word_t     out_value_r, out_value_nxt;
  pos_t      out_pos_r, out_pos_nxt;
  logic      out_last_r, out_last_nxt;

  cell_ctl_t ctl;
  word_t     words [DEPTH];
  word_t     prev_w [DEPTH];
  word_t     next_w [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] later;

  logic      slot_free;
  logic      accept;
  logic      any_later;
  logic      srch_last;
  logic      list_last;
  logic      list_adv;
  logic      cap_hit;
  idx_t      last_pos;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == FSM_IDLE) && slot_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign last_pos  = IDX_W'(fill_r - FILL_W'(1));
  assign cap_hit   = (cnt_r == CNT_W'(MAX_RESULTS));
  assign srch_last = !any_later || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign list_last = (pos_r == last_pos) || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign list_adv  = slot_free || cap_hit;

  // Matches past the current position
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      later[i] = hits[i] && (IDX_W'(i) > pos_r);
    end
  end
  assign any_later = |later;

  // Neighbor links of the cell row
  always_comb begin
    prev_w[0]       = '0;
    next_w[DEPTH-1] = words[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      prev_w[i]   = words[i-1];
      next_w[i-1] = words[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(g)),
      .prev_word (prev_w[g]),
      .next_word (next_w[g]),
      .head_word (words[0]),
      .word      (words[g]),
      .hit       (hits[g])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept && in_ch.action == ACT_SEARCH) begin
          state_nxt = FSM_SEARCH;
        end else if (accept && in_ch.action == ACT_LIST && fill_r != '0) begin
          state_nxt = FSM_LIST;
        end
      end
      FSM_SEARCH: begin
        if (slot_free && (hits == '0 || (hits[pos_r] && srch_last))) state_nxt = FSM_IDLE;
      end
      FSM_LIST: begin
        if (list_adv && pos_r == last_pos) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, cell control and result register
  always_comb begin
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    ctl.op         = CELL_HOLD;
    ctl.value      = in_ch.value;
    ctl.fill       = fill_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_value_nxt = '0;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
          unique case (in_ch.action)
            ACT_PUSH: begin
              out_valid_nxt = 1'b1;
              if (fill_r == FILL_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctl.op         = (mode_r == MODE_QUEUE) ? CELL_LOAD_AT : CELL_SHIFT_BACK;
                fill_nxt       = fill_r + FILL_W'(1);
                out_status_nxt = ST_DONE;
              end
            end
            ACT_POP: begin
              out_valid_nxt = 1'b1;
              if (fill_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ctl.op         = CELL_SHIFT_FWD;
                fill_nxt       = fill_r - FILL_W'(1);
                out_status_nxt = ST_DONE;
              end
            end
            ACT_SEARCH: begin
              ctl.op  = CELL_COMPARE;
              key_nxt = in_ch.value;
              pos_nxt = '0;
              cnt_nxt = '0;
            end
            ACT_LIST: begin
              pos_nxt = '0;
              cnt_nxt = '0;
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SEARCH: begin
        if (slot_free) begin
          if (hits == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOTFOUND;
            out_value_nxt  = '0;
            out_pos_nxt    = '0;
            out_last_nxt   = 1'b1;
          end else begin
            if (hits[pos_r]) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_MATCH;
              out_value_nxt  = key_r;
              out_pos_nxt    = POS_W'(pos_r);
              out_last_nxt   = srch_last;
              cnt_nxt        = cnt_r + CNT_W'(1);
            end
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
      end
      FSM_LIST: begin
        if (list_adv) begin
          ctl.op = CELL_ROTATE;
          if (!cap_hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LISTED;
            out_value_nxt  = words[0];
            out_pos_nxt    = POS_W'(pos_r);
            out_last_nxt   = list_last;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      mode_r      <= MODE_STACK;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) mode_r <= cfg_ch.data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.last      = out_last_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill count above depth");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != FSM_IDLE |-> !in_ch.ready)
    else $error("request taken during a walk");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == ACT_PUSH && fill_r != FILL_W'(DEPTH))
      |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("push did not grow the store");

  a_walk_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_LIST && slot_free && !cap_hit) |=> out_valid_r)
    else $error("list step without a result");

endmodule

### tb/tb_stack_or_queue_with_search.sv
module tb_stack_or_queue_with_search;
  import sqs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 40;

  // One result as it leaves out_ch
  typedef struct packed {
    status_t status;
    word_t   value_res;
    pos_t    position;
    logic    last;
  } outcome_t;

  // Mirror of the word store plus the results still owed by the block
  class word_store_mirror;
    word_t    slot[DEPTH];
    int       front;
    int       fill;
    mode_t    mode;
    outcome_t awaited[$];
    int       errors;

    function new();
      front  = 0;
      fill   = 0;
      mode   = MODE_STACK;
      errors = 0;
      foreach (slot[i]) slot[i] = '0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void owe(status_t s, word_t v, int p);
      outcome_t o;
      o.status    = s;
      o.value_res = v;
      o.position  = pos_t'(p);
      o.last      = 1'b0;
      awaited.push_back(o);
    endfunction

    // Apply one accepted request and queue the results it must produce
    function void predict_request(action_t act, word_t key);
      int n;
      int p;
      word_t w;
      n = 0;
      case (act)
        ACT_PUSH: begin
          if (fill >= DEPTH) begin
            owe(ST_FULL, '0, 0);
          end else begin
            if (mode == MODE_STACK) begin
              front = (front + DEPTH - 1) % DEPTH;
              slot[front] = key;
            end else begin
              slot[(front + fill) % DEPTH] = key;
            end
            fill++;
            owe(ST_DONE, '0, 0);
          end
          n = 1;
        end
        ACT_POP: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 0);
          end else begin
            front = (front + 1) % DEPTH;
            fill--;
            owe(ST_DONE, '0, 0);
          end
          n = 1;
        end
        ACT_SEARCH: begin
          for (p = 0; p < fill && n < MAX_RESULTS; p++) begin
            w = slot[(front + p) % DEPTH];
            if (w == key) begin
              owe(ST_MATCH, w, p);
              n++;
            end
          end
          if (n == 0) owe(ST_NOTFOUND, '0, 0);
        end
        ACT_LIST: begin
          for (p = 0; p < fill && n < MAX_RESULTS; p++) begin
            owe(ST_LISTED, slot[(front + p) % DEPTH], p);
            n++;
          end
          if (n == 0) owe(ST_EMPTY, '0, 0);
        end
      endcase
      awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare an accepted result against the oldest owed one
    task check_result(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unowed result status=%0d value=%0d pos=%0d last=%0b",
                                  got.status, got.value_res, got.position, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        report_mismatch($sformatf(
          "got/want status %0d/%0d value %0d/%0d pos %0d/%0d last %0b/%0b",
          got.status, want.status, got.value_res, want.value_res,
          got.position, want.position, got.last, want.last));
    endtask
  endclass

  logic  clk;
  logic  rst_n;
  bit    calm;
  bit    hold_req;
  int    cycles = 0;
  word_t pool[8];
  int    push_pct[PHASES] = '{80, 50, 30, 85, 20, 55, 65};
  word_store_mirror book;

  sqs_cfg_if cfg_ch();
  sqs_in_if  in_ch();
  sqs_out_if out_ch();

  stack_or_queue_with_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 8-unit clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int rest;
    rest = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rest     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rest > 0) begin
        out_ch.ready = 1'b0;
        rest--;
      end else begin
        out_ch.ready = 1'b1;
        rest = pick_gap();
      end
    end
  end

  // Check every result taken off out_ch
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status    = out_ch.status;
      got.value_res = out_ch.value_res;
      got.position  = out_ch.position;
      got.last      = out_ch.last;
      book.check_result(got);
    end
  end

  // Offer one item; called and returns at a falling edge
  task automatic send_item(action_t act, word_t val);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_ch.action = act;
    in_ch.value  = val;
    in_ch.valid  = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    book.predict_request(act, val);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_mode(mode_t m);
    cfg_ch.data  = m;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    book.set_mode(m);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Let every owed result drain, then a short settle
  task automatic wait_idle(int tail);
    while (book.pending() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Random request; values mostly from a small pool so searches hit
  task automatic random_item(int pct);
    int      r;
    action_t act;
    word_t   val;
    r = $urandom_range(99);
    if (r < pct) begin
      act = ACT_PUSH;
    end else begin
      r = $urandom_range(9);
      act = (r < 5) ? ACT_POP : (r < 8) ? ACT_SEARCH : ACT_LIST;
    end
    if ($urandom_range(9) < 7) val = pool[$urandom_range(7)];
    else val = word_t'($urandom);
    send_item(act, val);
  endtask

  initial begin
    book         = new();
    rst_n        = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = MODE_STACK;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.value  = '0;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = -32'sd1;
    pool[3] = '0;
    for (int k = 4; k < 8; k++) pool[k] = word_t'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, extremes, duplicates, stack order
    write_mode(MODE_STACK);
    send_item(ACT_POP, '0);
    send_item(ACT_LIST, '0);
    send_item(ACT_SEARCH, '0);
    send_item(ACT_PUSH, 32'sh8000_0000);
    send_item(ACT_PUSH, 32'sh7fff_ffff);
    send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_PUSH, '0);
    send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_LIST, '0);
    send_item(ACT_SEARCH, -32'sd1);
    send_item(ACT_SEARCH, 32'sd5);
    send_item(ACT_POP, '0);
    send_item(ACT_LIST, '0);
    send_item(ACT_SEARCH, 32'sh8000_0000);

    // Switch to queue with words still stored: front stays put
    wait_idle(4);
    write_mode(MODE_QUEUE);
    send_item(ACT_PUSH, 32'sh1234_5678);
    send_item(ACT_LIST, '0);
    send_item(ACT_POP, '0);
    send_item(ACT_LIST, '0);
    send_item(ACT_SEARCH, 32'sh7fff_ffff);

    // Random phases, alternating mode without draining the store
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      write_mode((ph % 2 == 0) ? MODE_QUEUE : MODE_STACK);
      calm = (ph == 5);
      for (int k = 4; k < 8; k++) pool[k] = word_t'($urandom);
      // long result-side hold while requests keep coming
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_item(push_pct[ph]);
    end

    wait_idle(40);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### stack_or_queue_with_search.f
src/sqs_pkg.sv
src/sqs_ifs.sv
src/sqs_cell.sv
src/stack_or_queue_with_search.sv
tb/tb_stack_or_queue_with_search.sv
